// ===== rtl/core/btks_pkg.sv =====
`timescale 1ns / 1ps

package btks_pkg;

  localparam int K_MAX_DEF      = 64;
  localparam int ORDER_BITS_DEF = 32;
  localparam int HANDLE_BITS    = 16;
  localparam int CLOUD_BITS     = 14;
  localparam int KEEP_BITS      = 7;
  localparam int COUNT_BITS     = 32;
  localparam int POS_BITS       = 6;

  localparam logic [KEEP_BITS-1:0] KEEP_RESET = KEEP_BITS'(64);

  // register index, decoded from paddr[2]
  localparam logic REG_KEEP  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic REQ_OFFER = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [HANDLE_BITS-1:0]  record_handle;
    logic                    has_cloud;
    logic [CLOUD_BITS-1:0]   cloud_cover;
    logic                    has_time;
    logic signed [63:0]      time_nanos;
    logic [63:0]             id_key;
  } in_t;

  typedef struct packed {
    logic                    has_entry;
    logic [HANDLE_BITS-1:0]  out_handle;
    logic [POS_BITS-1:0]     rank_position;
    logic                    last;
    logic [COUNT_BITS-1:0]   match_count;
    logic                    truncated;
  } out_t;

  // rank keys of one record, without the arrival order
  typedef struct packed {
    logic                    hc;
    logic [CLOUD_BITS-1:0]   cc;
    logic                    ht;
    logic signed [63:0]      t;
    logic [63:0]             key;
  } rank_t;

  typedef struct packed {
    rank_t                   rank;
    logic [HANDLE_BITS-1:0]  hnd;
  } rec_t;

  typedef struct packed {
    logic ins;    // insert the pending offer
    logic shift;  // move every record one cell toward the head
  } chain_ctl_t;

endpackage

// ===== rtl/core/bounded_top_k_rank_selector_top.sv =====
`timescale 1ns / 1ps

// channel   handshake                          payload
// in        start, busy (accept: start & !busy) in_data   (btks_pkg::in_t)
// out       out_strobe, high with each result   out_data  (btks_pkg::out_t)
// cfg       psel, penable, pwrite, pready       paddr, pwdata, prdata
//
// An offer is taken every cycle while busy is low; it waits in a pending register and
// is inserted into the sorted cell chain (cell 0 best) on the next edge. A flush
// raises busy until the kept records are emitted (one empty result if none); each
// busy cycle shifts the chain one cell toward the head and registers one result.
// Synchronous active-low reset clears the fill count, counters and handshake state;
// the cells themselves are not reset. Results cannot be held off by the receiver.
module bounded_top_k_rank_selector_top #(
  parameter int K_MAX      = btks_pkg::K_MAX_DEF,
  parameter int ORDER_BITS = btks_pkg::ORDER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  btks_pkg::in_t    in_data,
  output logic             out_strobe,
  output btks_pkg::out_t   out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int FILL_W = $clog2(K_MAX + 1);
  localparam int KW     = (FILL_W > btks_pkg::KEEP_BITS) ? FILL_W : btks_pkg::KEEP_BITS;
  localparam int PW     = (FILL_W > btks_pkg::POS_BITS) ? FILL_W : btks_pkg::POS_BITS;
  localparam int CW     = btks_pkg::COUNT_BITS;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t                          state_r;
  logic [btks_pkg::KEEP_BITS-1:0]  keep_r;
  logic [CW-1:0]                   limit_r;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic [CW-1:0]                   offer_cnt_r;
  logic [ORDER_BITS-1:0]           arrival_r;
  logic                            limit_hit_r;
  logic                            pend_valid_r;
  btks_pkg::rec_t                  pend_rec_r;
  logic [ORDER_BITS-1:0]           pend_ord_r;
  logic [PW-1:0]                   pos_r;
  logic                            strobe_r;
  btks_pkg::out_t                  out_r;

  logic                            accept, cfg_wr, offer_ok, full, last_c, trunc_c;
  logic [KW-1:0]                   keep_x, eff_keep, fill_x;
  logic [FILL_W-1:0]               bound;
  btks_pkg::chain_ctl_t            ctl;
  btks_pkg::rec_t                  head_rec;
  btks_pkg::rec_t                  in_rec;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  assign keep_x   = KW'(keep_r);
  assign eff_keep = (keep_x == '0) ? KW'(1) :
                    (keep_x > KW'(K_MAX)) ? KW'(K_MAX) : keep_x;
  assign fill_x   = KW'(fill_r);
  assign full     = fill_x >= eff_keep;
  // a full store only reorders its occupied cells and drops the worst
  assign bound    = full ? fill_r : fill_r + FILL_W'(1);
  // the last flush cycle empties the store
  assign fill_nxt = ((state_r == ST_EMIT) && last_c) ? '0 :
                    (pend_valid_r && !full) ? fill_r + FILL_W'(1) : fill_r;

  assign offer_ok = (limit_r == '0) || (offer_cnt_r < limit_r);

  assign ctl.ins   = pend_valid_r;
  assign ctl.shift = (state_r == ST_EMIT);

  assign last_c  = (fill_r == '0) || (pos_r == PW'(fill_r - FILL_W'(1)));
  assign trunc_c = limit_hit_r || ((offer_cnt_r > CW'(fill_r)) && (fill_x >= eff_keep));

  assign in_rec.rank.hc = in_data.has_cloud;
  assign in_rec.rank.cc = in_data.cloud_cover;
  assign in_rec.rank.ht = in_data.has_time;
  assign in_rec.rank.t  = in_data.time_nanos;
  assign in_rec.rank.key = in_data.id_key;
  assign in_rec.hnd     = in_data.record_handle;

  btks_chain #(
    .K_MAX      (K_MAX),
    .ORDER_BITS (ORDER_BITS)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .fill     (fill_r),
    .bound    (bound),
    .new_rec  (pend_rec_r),
    .new_ord  (pend_ord_r),
    .head_rec (head_rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keep_r       <= btks_pkg::KEEP_RESET;
      limit_r      <= '0;
      fill_r       <= '0;
      offer_cnt_r  <= '0;
      arrival_r    <= '0;
      limit_hit_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      pos_r        <= '0;
      strobe_r     <= 1'b0;
    end else begin
      fill_r <= fill_nxt;

      if (cfg_wr) begin
        unique case (paddr[2])
          btks_pkg::REG_KEEP:  keep_r  <= pwdata[btks_pkg::KEEP_BITS-1:0];
          btks_pkg::REG_LIMIT: limit_r <= pwdata;
          default:             ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          strobe_r     <= 1'b0;
          pend_valid_r <= accept && (in_data.req_type == btks_pkg::REQ_OFFER) && offer_ok;
          if (accept) begin
            if (in_data.req_type == btks_pkg::REQ_FLUSH) begin
              state_r <= ST_EMIT;
              pos_r   <= '0;
            end else if (!offer_ok) begin
              limit_hit_r <= 1'b1;
            end else begin
              if (offer_cnt_r != '1) begin
                offer_cnt_r <= offer_cnt_r + CW'(1);
              end
              arrival_r    <= arrival_r + ORDER_BITS'(1);
              pend_rec_r   <= in_rec;
              pend_ord_r   <= arrival_r;
            end
          end
        end
        ST_EMIT: begin
          strobe_r                <= 1'b1;
          pend_valid_r            <= 1'b0;
          out_r.has_entry         <= (fill_r != '0);
          out_r.out_handle        <= (fill_r != '0) ? head_rec.hnd : '0;
          out_r.rank_position     <= pos_r[btks_pkg::POS_BITS-1:0];
          out_r.last              <= last_c;
          out_r.match_count       <= offer_cnt_r;
          out_r.truncated         <= trunc_c;
          pos_r                   <= pos_r + PW'(1);
          if (last_c) begin
            state_r     <= ST_IDLE;
            offer_cnt_r <= '0;
            arrival_r   <= '0;
            limit_hit_r <= 1'b0;
          end
        end
        default: begin
          state_r      <= ST_IDLE;
          strobe_r     <= 1'b0;
          pend_valid_r <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      btks_pkg::REG_KEEP:  prdata = 32'(keep_r);
      btks_pkg::REG_LIMIT: prdata = limit_r;
      default:             prdata = '0;
    endcase
  end

  assign busy       = (state_r == ST_EMIT);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

// ===== rtl/core/btks_cell.sv =====
`timescale 1ns / 1ps

module btks_cell #(
  parameter int ORDER_BITS = btks_pkg::ORDER_BITS_DEF
) (
  input  logic                    clk,
  input  btks_pkg::chain_ctl_t    ctl,
  input  logic                    occupied,
  input  logic                    enable,
  input  btks_pkg::rec_t          new_rec,
  input  logic [ORDER_BITS-1:0]   new_ord,
  input  logic                    prev_take,
  input  btks_pkg::rec_t          prev_rec,
  input  logic [ORDER_BITS-1:0]   prev_ord,
  input  btks_pkg::rec_t          next_rec,
  input  logic [ORDER_BITS-1:0]   next_ord,
  output logic                    take,
  output btks_pkg::rec_t          rec,
  output logic [ORDER_BITS-1:0]   ord
);

  typedef enum logic [1:0] {CMP_BETTER, CMP_EQUAL, CMP_WORSE} cmp_t;

  btks_pkg::rec_t        rec_r;
  logic [ORDER_BITS-1:0] ord_r;
  cmp_t                  cmp;
  logic                  new_better;

  function automatic cmp_t rank_cmp(btks_pkg::rank_t a, btks_pkg::rank_t b);
    cmp_t c;
    if (a.hc != b.hc) begin
      c = a.hc ? CMP_BETTER : CMP_WORSE;
    end else if (a.hc && (a.cc != b.cc)) begin
      c = (a.cc < b.cc) ? CMP_BETTER : CMP_WORSE;
    end else if (a.ht != b.ht) begin
      c = a.ht ? CMP_BETTER : CMP_WORSE;
    end else if (a.ht && (a.t != b.t)) begin
      c = ($signed(a.t) > $signed(b.t)) ? CMP_BETTER : CMP_WORSE;
    end else if (a.key != b.key) begin
      c = (a.key < b.key) ? CMP_BETTER : CMP_WORSE;
    end else begin
      c = CMP_EQUAL;
    end
    return c;
  endfunction

  assign cmp        = rank_cmp(new_rec.rank, rec_r.rank);
  assign new_better = (cmp == CMP_BETTER) || ((cmp == CMP_EQUAL) && (new_ord < ord_r));

  // takes on the chain are monotone: from the first taking cell onward, every cell
  // up to the enable bound takes, each passing its old record to the next
  assign take = ctl.ins && enable && (!occupied || new_better);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rec_r <= next_rec;
      ord_r <= next_ord;
    end else if (take) begin
      rec_r <= prev_take ? prev_rec : new_rec;
      ord_r <= prev_take ? prev_ord : new_ord;
    end
  end

  assign rec = rec_r;
  assign ord = ord_r;

endmodule

// ===== rtl/core/btks_chain.sv =====
`timescale 1ns / 1ps

module btks_chain #(
  parameter int K_MAX      = btks_pkg::K_MAX_DEF,
  parameter int ORDER_BITS = btks_pkg::ORDER_BITS_DEF,
  localparam int FILL_W    = $clog2(K_MAX + 1)
) (
  input  logic                  clk,
  input  btks_pkg::chain_ctl_t  ctl,
  input  logic [FILL_W-1:0]     fill,
  input  logic [FILL_W-1:0]     bound,
  input  btks_pkg::rec_t        new_rec,
  input  logic [ORDER_BITS-1:0] new_ord,
  output btks_pkg::rec_t        head_rec
);

  logic                  take [K_MAX];
  btks_pkg::rec_t        rec  [K_MAX];
  logic [ORDER_BITS-1:0] ord  [K_MAX];

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic                  p_take;
    btks_pkg::rec_t        p_rec;
    logic [ORDER_BITS-1:0] p_ord;
    btks_pkg::rec_t        n_rec;
    logic [ORDER_BITS-1:0] n_ord;

    if (i == 0) begin : g_head
      assign p_take = 1'b0;
      assign p_rec  = new_rec;
      assign p_ord  = new_ord;
    end else begin : g_body
      assign p_take = take[i-1];
      assign p_rec  = rec[i-1];
      assign p_ord  = ord[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign n_rec = rec[i];
      assign n_ord = ord[i];
    end else begin : g_mid
      assign n_rec = rec[i+1];
      assign n_ord = ord[i+1];
    end

    btks_cell #(
      .ORDER_BITS (ORDER_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (FILL_W'(i) < fill),
      .enable    (FILL_W'(i) < bound),
      .new_rec   (new_rec),
      .new_ord   (new_ord),
      .prev_take (p_take),
      .prev_rec  (p_rec),
      .prev_ord  (p_ord),
      .next_rec  (n_rec),
      .next_ord  (n_ord),
      .take      (take[i]),
      .rec       (rec[i]),
      .ord       (ord[i])
    );
  end

  assign head_rec = rec[0];

endmodule

// ===== test/btks_checker.sv =====
`timescale 1ns / 1ps

// Watches the offer, result and register ports, keeps a shadow of the kept
// records and checks every flush result against the predicted ranking.
module btks_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  btks_pkg::in_t   in_data,
  input  logic            out_strobe,
  input  btks_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic            pready,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic [31:0]     prdata,
  output int              fail_count,
  output int              awaited,
  output int              results_seen
);

  typedef struct packed {
    btks_pkg::rank_t                     keys;
    logic [btks_pkg::ORDER_BITS_DEF-1:0] ord;
    logic [btks_pkg::HANDLE_BITS-1:0]    hnd;
  } held_rec_t;

  held_rec_t                           held[btks_pkg::K_MAX_DEF];
  int                                  fill;
  logic [btks_pkg::COUNT_BITS-1:0]     offers_counted;
  logic [btks_pkg::ORDER_BITS_DEF-1:0] arrival;
  bit                                  limit_seen;
  logic [btks_pkg::KEEP_BITS-1:0]      keep_reg;
  logic [31:0]                         limit_reg;
  btks_pkg::out_t                      ranked_results_q[$];

  // a strictly ahead of b in best-first order
  function automatic bit outranks(held_rec_t a, held_rec_t b);
    if (a.keys.hc != b.keys.hc) return a.keys.hc;
    if (a.keys.hc && a.keys.cc != b.keys.cc) return a.keys.cc < b.keys.cc;
    if (a.keys.ht != b.keys.ht) return a.keys.ht;
    if (a.keys.ht && a.keys.t != b.keys.t) return $signed(a.keys.t) > $signed(b.keys.t);
    if (a.keys.key != b.keys.key) return a.keys.key < b.keys.key;
    return a.ord < b.ord;
  endfunction

  function automatic int budget();
    if (keep_reg == 0) return 1;
    if (keep_reg > btks_pkg::K_MAX_DEF) return btks_pkg::K_MAX_DEF;
    return int'(keep_reg);
  endfunction

  task automatic take_offer(input btks_pkg::in_t o);
    held_rec_t r;
    int        worst;
    int        k;
    k = budget();
    if (limit_reg != 0 && offers_counted >= limit_reg) begin
      limit_seen = 1'b1;
      return;
    end
    if (offers_counted != '1) offers_counted++;
    r.keys.hc  = o.has_cloud;
    r.keys.cc  = o.cloud_cover;
    r.keys.ht  = o.has_time;
    r.keys.t   = o.time_nanos;
    r.keys.key = o.id_key;
    r.ord      = arrival;
    r.hnd      = o.record_handle;
    arrival++;
    if (fill < k) begin
      held[fill] = r;
      fill++;
    end else if (fill > 0) begin
      worst = 0;
      for (int i = 1; i < fill; i++) begin
        if (outranks(held[worst], held[i])) worst = i;
      end
      // an exact tie with the worst loses on arrival, so it is dropped
      if (outranks(r, held[worst])) held[worst] = r;
    end
  endtask

  task automatic emit_ranking();
    held_rec_t      ordered[$];
    held_rec_t      v;
    btks_pkg::out_t res;
    int             j;
    bit             trunc;
    trunc = limit_seen || (offers_counted > fill && fill >= budget());
    for (int i = 0; i < fill; i++) begin
      v = held[i];
      j = ordered.size();
      while (j > 0 && outranks(v, ordered[j-1])) j--;
      ordered.insert(j, v);
    end
    if (fill == 0) begin
      res = '0;
      res.last        = 1'b1;
      res.match_count = offers_counted;
      res.truncated   = trunc;
      ranked_results_q.insert(ranked_results_q.size(), res);
    end else begin
      for (int i = 0; i < fill; i++) begin
        res.has_entry     = 1'b1;
        res.out_handle    = ordered[i].hnd;
        res.rank_position = i[btks_pkg::POS_BITS-1:0];
        res.last          = (i == fill - 1);
        res.match_count   = offers_counted;
        res.truncated     = trunc;
        ranked_results_q.insert(ranked_results_q.size(), res);
      end
    end
    fill           = 0;
    offers_counted = '0;
    arrival        = '0;
    limit_seen     = 1'b0;
  endtask

  function automatic bit field_ok(string name, logic [63:0] exp, logic [63:0] got);
    if (got === exp) return 1'b1;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    btks_pkg::out_t exp_r;
    int             bad;
    logic [31:0]    exp_rd;
    if (!rst_n) begin
      fill           = 0;
      offers_counted = '0;
      arrival        = '0;
      limit_seen     = 1'b0;
      keep_reg       = btks_pkg::KEEP_RESET;
      limit_reg      = '0;
      fail_count     = 0;
      results_seen   = 0;
      ranked_results_q.delete();
    end else begin
      if (out_strobe) begin
        results_seen++;
        if (ranked_results_q.size() == 0) begin
          $display("%0t: result with none expected, got 0x%0h", $time, out_data);
          fail_count++;
        end else begin
          exp_r = ranked_results_q.pop_front();
          bad = 0;
          if (!field_ok("has_entry", 64'(exp_r.has_entry), 64'(out_data.has_entry)))
            bad++;
          if (!field_ok("out_handle", 64'(exp_r.out_handle), 64'(out_data.out_handle)))
            bad++;
          if (!field_ok("rank_position", 64'(exp_r.rank_position),
                        64'(out_data.rank_position)))
            bad++;
          if (!field_ok("last", 64'(exp_r.last), 64'(out_data.last))) bad++;
          if (!field_ok("match_count", 64'(exp_r.match_count),
                        64'(out_data.match_count)))
            bad++;
          if (!field_ok("truncated", 64'(exp_r.truncated), 64'(out_data.truncated)))
            bad++;
          if (bad != 0) fail_count++;
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == btks_pkg::REG_LIMIT) limit_reg = pwdata;
          else keep_reg = pwdata[btks_pkg::KEEP_BITS-1:0];
        end else begin
          exp_rd = (paddr[2] == btks_pkg::REG_LIMIT) ? limit_reg : 32'(keep_reg);
          if (!field_ok("prdata", 64'(exp_rd), 64'(prdata))) fail_count++;
        end
      end
      if (start && !busy) begin
        if (in_data.req_type == btks_pkg::REQ_OFFER) take_offer(in_data);
        else emit_ranking();
      end
    end
    awaited = ranked_results_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TOTAL_ITEMS = 260;
  localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  btks_pkg::in_t  in_data;
  logic           out_strobe;
  btks_pkg::out_t out_data;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  int fail_count;
  int awaited;
  int results_seen;
  int cycles = 0;
  int items_sent = 0;
  int flushes_sent = 0;
  bit burst_mode = 1'b0;

  bounded_top_k_rank_selector_top dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  btks_checker rank_chk (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .fail_count(fail_count), .awaited(awaited), .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycles, awaited);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic btks_pkg::in_t directed_offer(logic [15:0] h, logic hc,
                                                   logic [13:0] cc, logic ht,
                                                   logic [63:0] t, logic [63:0] key);
    btks_pkg::in_t o;
    o.req_type      = btks_pkg::REQ_OFFER;
    o.record_handle = h;
    o.has_cloud     = hc;
    o.cloud_cover   = cc;
    o.has_time      = ht;
    o.time_nanos    = t;
    o.id_key        = key;
    return o;
  endfunction

  // keys drawn partly from small pools so that ties reach the later rank stages
  function automatic btks_pkg::in_t make_offer();
    btks_pkg::in_t o;
    o.req_type      = btks_pkg::REQ_OFFER;
    o.record_handle = 16'($urandom);
    o.has_cloud     = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0:       o.cloud_cover = 14'($urandom_range(0, 16383));
      1:       o.cloud_cover = 14'($urandom_range(0, 10000));
      2:       o.cloud_cover = 14'd0;
      default: o.cloud_cover = 14'd2500;
    endcase
    o.has_time = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 5))
      0, 1:    o.time_nanos = {$urandom, $urandom};
      2:       o.time_nanos = T_MIN;
      3:       o.time_nanos = T_MAX;
      4:       o.time_nanos = '1;
      default: o.time_nanos = 64'd1_700_000_000_000_000_000;
    endcase
    if ($urandom_range(0, 1) == 0) o.id_key = {$urandom, $urandom};
    else o.id_key = 64'($urandom_range(0, 3));
    return o;
  endfunction

  function automatic btks_pkg::in_t make_flush();
    logic [191:0]  raw;
    btks_pkg::in_t o;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    o = raw[$bits(btks_pkg::in_t)-1:0];
    o.req_type = btks_pkg::REQ_FLUSH;
    return o;
  endfunction

  task automatic send(input btks_pkg::in_t item);
    @(negedge clk);
    in_data <= item;
    start   <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items_sent++;
    if (item.req_type == btks_pkg::REQ_FLUSH) flushes_sent++;
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold off until every result is back and the pending offer has landed
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait (awaited == 0);
    repeat (4) @(negedge clk);
  endtask

  // write, then read back; the checker tracks both transfers
  task automatic set_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [6:0] keep, input logic [31:0] limit);
    settle();
    set_reg(btks_pkg::REG_KEEP, 32'(keep));
    @(negedge clk);
    set_reg(btks_pkg::REG_LIMIT, limit);
  endtask

  initial begin
    int n_offers;
    int r;
    logic [6:0]  keep;
    logic [31:0] limit;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // flush with nothing kept
    send(make_flush());

    // ties resolved at each stage of the order, store full at three
    set_config(7'd3, 32'd0);
    send(directed_offer(16'hFFFF, 1'b0, 14'h3FFF, 1'b1, T_MAX, 64'd0));
    send(directed_offer(16'h0000, 1'b1, 14'h3FFF, 1'b0, T_MIN, '1));
    send(directed_offer(16'h0001, 1'b1, 14'd0, 1'b1, T_MIN, 64'd5));
    send(directed_offer(16'h0002, 1'b1, 14'd0, 1'b1, T_MIN, 64'd5));
    send(directed_offer(16'h0003, 1'b1, 14'd0, 1'b1, T_MAX, 64'd5));
    send(directed_offer(16'h0004, 1'b1, 14'd10000, 1'b1, '1, 64'd0));
    send(make_flush());

    // zero budget acts as one; limit of two drops the third offer
    set_config(7'd0, 32'd2);
    send(directed_offer(16'h1111, 1'b0, 14'd7, 1'b0, 64'd9, 64'd3));
    send(directed_offer(16'h2222, 1'b0, 14'd1, 1'b0, T_MAX, 64'd3));
    send(directed_offer(16'h3333, 1'b1, 14'd0, 1'b1, T_MAX, 64'd0));
    send(make_flush());

    // budget above the maximum, then lowered below the fill level
    set_config(7'd127, 32'hFFFF_FFFF);
    repeat (4) send(make_offer());
    settle();
    set_reg(btks_pkg::REG_KEEP, 32'd2);
    repeat (2) send(make_offer());
    send(make_flush());

    set_config(7'd64, 32'd1);
    repeat (2) send(make_offer());
    send(make_flush());

    while (items_sent < TOTAL_ITEMS) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) keep = 7'd0;
        else if (r == 1) keep = 7'd64;
        else if (r == 2) keep = 7'($urandom_range(65, 127));
        else keep = 7'($urandom_range(1, 8));
        r = $urandom_range(0, 9);
        if (r < 6) limit = 32'd0;
        else if (r < 8) limit = $urandom_range(1, 10);
        else if (r == 8) limit = 32'hFFFF_FFFF;
        else limit = $urandom;
        set_config(keep, limit);
      end
      r = $urandom_range(0, 9);
      if (r == 0) n_offers = 0;
      else if (r < 8) n_offers = $urandom_range(1, 12);
      else n_offers = $urandom_range(40, 80);
      // keep the total near the planned item count
      if (n_offers > TOTAL_ITEMS - items_sent - 1)
        n_offers = TOTAL_ITEMS - items_sent - 1;
      if (n_offers < 0) n_offers = 0;
      for (int i = 0; i < n_offers; i++) begin
        if (i == n_offers / 2 && n_offers > 3 && $urandom_range(0, 3) == 0) begin
          settle();
          set_reg(btks_pkg::REG_KEEP, 32'($urandom_range(0, 127)));
        end
        send(make_offer());
        idle_gap();
      end
      send(make_flush());
      idle_gap();
    end

    @(negedge clk);
    start <= 1'b0;
    wait (awaited == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d items including %0d flushes; %0d results checked.",
             items_sent, flushes_sent, results_seen);
    $display("Budgets 0, small, 64 and over 64, limits 0 to max, keep lowered mid-fill.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
